/* rtl/gtq_pkg.sv */
package gtq_pkg;

	localparam int OP_W       = 2;
	localparam int ELEM_W     = 10;
	localparam int TEAM_W     = 10;
	localparam int VAL_W      = 10;
	localparam int STAT_W     = 2;
	localparam int EPOCH_BITS = 8;

	localparam logic [OP_W-1:0] OP_MAP = 2'd0;
	localparam logic [OP_W-1:0] OP_ENQ = 2'd1;
	localparam logic [OP_W-1:0] OP_DEQ = 2'd2;
	localparam logic [OP_W-1:0] OP_CLR = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic accept;
		logic enq_alloc;
		logic enq_link;
		logic enq_split_a;
		logic enq_split_b;
		logic deq_pop;
		logic deq_fix;
		logic sweep;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic team_hit;
		logic sweep_last;
		logic epoch_max;
	} sts_t;

endpackage

/* rtl/gtq_channels.sv */
interface gtq_req_if;
	import gtq_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ELEM_W-1:0] element;
	logic [TEAM_W-1:0] team_id;
	modport source(output valid, opcode, element, team_id, input ready);
	modport sink(input valid, opcode, element, team_id, output ready);
endinterface

interface gtq_rsp_if;
	import gtq_pkg::*;
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  value_out;
	logic [STAT_W-1:0] status;
	modport source(output valid, value_out, status, input ready);
	modport sink(input valid, value_out, status, output ready);
endinterface

/* rtl/grouped_team_queue_unit.sv */
// team queue: a fifo in which queued elements of one team stay side by side
// req channel: one beat per operation (opcode, element, team_id)
//   map = record the team of an element, enqueue, dequeue, clear
// rsp channel: exactly one beat per request (value_out, status)
//   status ok, empty on a dequeue with nothing queued, full on an enqueue
//   with every pool slot in use; value_out is zero except for a dequeue
// request steps: map, clear and rejected operations go straight to the
//   response; dequeue pops, then fixes; enqueue allocates and links (new
//   team at tail), then splits a and b to insert behind a team member,
//   set by registered reads and single-port writes on slot link memory
// one request is in work at a time; req.ready is high only when idle
// a finished beat sits in the rsp register, so the next request is taken
//   while the receiver stalls; a stalled beat holds its value
// after reset the team pointer memory is swept with req.ready low; the
//   same sweep follows every 256th clear, when the clear epoch wraps, and
//   then delays that clear's response
module grouped_team_queue_unit #(
	parameter int POOL_SLOTS   = 1024,
	parameter int TEAM_COUNT   = 1024,
	parameter int ELEMENT_BITS = 10
) (
	input logic      clk,
	input logic      arst_n,
	gtq_req_if.sink  req,
	gtq_rsp_if.source rsp
);
	import gtq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.opcode    (req.opcode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gtq_datapath #(
		.POOL_SLOTS   (POOL_SLOTS),
		.TEAM_COUNT   (TEAM_COUNT),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (req.opcode),
		.element   (req.element),
		.team_id   (req.team_id),
		.value_out (rsp.value_out),
		.status    (rsp.status)
	);

endmodule

/* rtl/gtq_ctrl.sv */
module gtq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [gtq_pkg::OP_W-1:0]    opcode,
	output logic                        req_ready,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  gtq_pkg::sts_t               sts,
	output gtq_pkg::cmd_t               cmd
);
	import gtq_pkg::*;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_E1,
		S_E2,
		S_E3,
		S_E4,
		S_D1,
		S_D2,
		S_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   after_clear_q;
	logic   accept;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.accept      = accept;
		cmd.enq_alloc   = (state_q == S_E1);
		cmd.enq_link    = (state_q == S_E2);
		cmd.enq_split_a = (state_q == S_E3);
		cmd.enq_split_b = (state_q == S_E4);
		cmd.deq_pop     = (state_q == S_D1);
		cmd.deq_fix     = (state_q == S_D2);
		cmd.sweep       = (state_q == S_SWEEP);
		cmd.load_out    = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			rsp_valid_q   <= 1'b0;
			after_clear_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (sts.sweep_last) begin
						state_q       <= after_clear_q ? S_DONE : S_IDLE;
						after_clear_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							OP_MAP: state_q <= S_DONE;
							OP_ENQ: state_q <= sts.full ? S_DONE : S_E1;
							OP_DEQ: state_q <= sts.empty ? S_DONE : S_D1;
							OP_CLR: begin
								// epoch wraps: stale team pointers must be wiped
								if (sts.epoch_max) begin
									state_q       <= S_SWEEP;
									after_clear_q <= 1'b1;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: state_q <= sts.team_hit ? S_E3 : S_DONE;
				S_E3: state_q <= S_E4;
				S_E4: state_q <= S_DONE;
				S_D1: state_q <= S_D2;
				S_D2: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/gtq_datapath.sv */
module gtq_datapath #(
	parameter int POOL_SLOTS   = 1024,
	parameter int TEAM_COUNT   = 1024,
	parameter int ELEMENT_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gtq_pkg::cmd_t                 cmd,
	output gtq_pkg::sts_t                 sts,
	input  logic [gtq_pkg::OP_W-1:0]      opcode,
	input  logic [gtq_pkg::ELEM_W-1:0]    element,
	input  logic [gtq_pkg::TEAM_W-1:0]    team_id,
	output logic [gtq_pkg::VAL_W-1:0]     value_out,
	output logic [gtq_pkg::STAT_W-1:0]    status
);
	import gtq_pkg::*;

	localparam int PB     = $clog2(POOL_SLOTS);
	localparam int CW     = PB + 1;
	localparam int TB     = (TEAM_COUNT > 1) ? $clog2(TEAM_COUNT) : 1;
	localparam int EB     = ELEMENT_BITS;
	localparam int EDEPTH = 1 << EB;
	localparam int EW     = (EB < ELEM_W) ? EB : ELEM_W;
	localparam int SW     = EW + TB;
	localparam int LW     = 1 + EPOCH_BITS + PB;

	// storage
	logic [TB-1:0] tmap_mem  [EDEPTH];
	logic [SW-1:0] sval_mem  [POOL_SLOTS];
	logic [PB-1:0] snext_mem [POOL_SLOTS];
	logic [LW-1:0] tlast_mem [TEAM_COUNT];

	logic [TB-1:0] tmap_rd_q;
	logic [SW-1:0] sval_rd_q;
	logic [PB-1:0] snx_rd_q;
	logic [LW-1:0] tlast_rd_q;

	// queue state
	logic [PB-1:0]         head_q, tail_q, free_q;
	logic [CW-1:0]         count_q, fresh_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [TB-1:0]         sweep_q;

	// per-item working registers
	logic [EW-1:0]     elem_q;
	logic [PB-1:0]     s_q, f_q;
	logic [TB-1:0]     t_q;
	logic [VAL_W-1:0]  vout_q, val_out_q;
	logic [STAT_W-1:0] stat_q, stat_out_q;

	logic          op_map, op_enq, op_deq, op_clr;
	logic [EB-1:0] key;
	logic          team_ok, full, empty, free_avail, hit, sweep_last;
	logic          tl_valid;
	logic [EPOCH_BITS-1:0] tl_epoch;
	logic [PB-1:0] tl_slot, alloc_slot;
	logic [EW-1:0] sv_elem;
	logic [TB-1:0] sv_team;

	logic          snx_we, snx_re;
	logic [PB-1:0] snx_wa, snx_wd, snx_ra;
	logic          tl_we, tl_re;
	logic [TB-1:0] tl_wa, tl_ra;
	logic [LW-1:0] tl_wd;

	assign op_map = (opcode == OP_MAP);
	assign op_enq = (opcode == OP_ENQ);
	assign op_deq = (opcode == OP_DEQ);
	assign op_clr = (opcode == OP_CLR);

	assign key        = EB'(element);
	assign team_ok    = int'(team_id) < TEAM_COUNT;
	assign empty      = (count_q == '0);
	assign full       = (count_q == fresh_q) && (fresh_q == CW'(POOL_SLOTS));
	assign free_avail = (count_q < fresh_q);
	assign alloc_slot = free_avail ? free_q : fresh_q[PB-1:0];

	assign tl_valid = tlast_rd_q[LW-1];
	assign tl_epoch = tlast_rd_q[LW-2:PB];
	assign tl_slot  = tlast_rd_q[PB-1:0];
	// an entry written before the last clear carries an older epoch
	assign hit      = tl_valid && (tl_epoch == epoch_q);

	assign sv_elem = sval_rd_q[EW-1:0];
	assign sv_team = sval_rd_q[SW-1:EW];

	assign sweep_last = (sweep_q == TB'(TEAM_COUNT - 1));

	assign sts.empty      = empty;
	assign sts.full       = full;
	assign sts.team_hit   = hit;
	assign sts.sweep_last = sweep_last;
	assign sts.epoch_max  = &epoch_q;

	assign value_out = val_out_q;
	assign status    = stat_out_q;

	// team table
	always_ff @(posedge clk) begin
		if (cmd.accept && op_map && team_ok) begin
			tmap_mem[key] <= TB'(team_id);
		end
		if (cmd.accept) begin
			tmap_rd_q <= tmap_mem[key];
		end
	end

	// slot values
	always_ff @(posedge clk) begin
		if (cmd.enq_alloc) begin
			sval_mem[alloc_slot] <= {tmap_rd_q, elem_q};
		end
		if (cmd.accept) begin
			sval_rd_q <= sval_mem[head_q];
		end
	end

	// slot links
	always_comb begin
		snx_we = 1'b0;
		snx_wa = s_q;
		snx_wd = s_q;
		if (cmd.deq_pop) begin
			snx_we = 1'b1;
			snx_wa = head_q;
			snx_wd = free_q;
		end else if (cmd.enq_link && !hit && !empty) begin
			snx_we = 1'b1;
			snx_wa = tail_q;
			snx_wd = s_q;
		end else if (cmd.enq_split_a) begin
			snx_we = 1'b1;
			snx_wa = s_q;
			snx_wd = snx_rd_q;
		end else if (cmd.enq_split_b) begin
			snx_we = 1'b1;
			snx_wa = f_q;
			snx_wd = s_q;
		end
		snx_re = cmd.accept || cmd.enq_link;
		snx_ra = cmd.enq_link ? tl_slot : (op_deq ? head_q : free_q);
	end

	always_ff @(posedge clk) begin
		if (snx_we) begin
			snext_mem[snx_wa] <= snx_wd;
		end
		if (snx_re) begin
			snx_rd_q <= snext_mem[snx_ra];
		end
	end

	// team last-member pointers
	always_comb begin
		tl_we = 1'b0;
		tl_wa = t_q;
		tl_wd = {1'b1, epoch_q, s_q};
		if (cmd.sweep) begin
			tl_we = 1'b1;
			tl_wa = sweep_q;
			tl_wd = '0;
		end else if (cmd.enq_link) begin
			tl_we = 1'b1;
		end else if (cmd.deq_fix && hit && (tl_slot == s_q)) begin
			tl_we = 1'b1;
			tl_wd = {1'b0, epoch_q, s_q};
		end
		tl_re = cmd.enq_alloc || cmd.deq_pop;
		tl_ra = cmd.deq_pop ? sv_team : tmap_rd_q;
	end

	always_ff @(posedge clk) begin
		if (tl_we) begin
			tlast_mem[tl_wa] <= tl_wd;
		end
		if (tl_re) begin
			tlast_rd_q <= tlast_mem[tl_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			epoch_q <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.accept && op_clr) begin
				head_q  <= '0;
				tail_q  <= '0;
				free_q  <= '0;
				count_q <= '0;
				fresh_q <= '0;
				epoch_q <= epoch_q + 1'b1;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (cmd.enq_alloc) begin
				if (free_avail) begin
					free_q <= snx_rd_q;
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
			if (cmd.enq_link) begin
				if (hit) begin
					if (tail_q == tl_slot) begin
						tail_q <= s_q;
					end
				end else begin
					if (empty) begin
						head_q <= s_q;
					end
					tail_q <= s_q;
				end
				count_q <= count_q + 1'b1;
			end
			if (cmd.deq_pop) begin
				head_q  <= snx_rd_q;
				free_q  <= head_q;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elem_q <= element[EW-1:0];
			vout_q <= '0;
			if (op_enq && full) begin
				stat_q <= ST_FULL;
			end else if (op_deq && empty) begin
				stat_q <= ST_EMPTY;
			end else begin
				stat_q <= ST_OK;
			end
		end
		if (cmd.enq_alloc) begin
			s_q <= alloc_slot;
			t_q <= tmap_rd_q;
		end
		if (cmd.enq_link) begin
			f_q <= tl_slot;
		end
		if (cmd.deq_pop) begin
			vout_q <= VAL_W'(sv_elem);
			s_q    <= head_q;
			t_q    <= sv_team;
		end
		if (cmd.load_out) begin
			val_out_q  <= vout_q;
			stat_out_q <= stat_q;
		end
	end

endmodule

/* rtl/gtq_checker.sv */
module gtq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [gtq_pkg::VAL_W-1:0]  value_out,
	input logic [gtq_pkg::STAT_W-1:0] status
);
	import gtq_pkg::*;

	logic [1:0] pending_q;
	logic       req_beat, rsp_beat;

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_beat) - 2'(rsp_beat);
		end
	end

	// one request in work plus one waiting response at most
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |-> pending_q <= 2'd1)
		else $error("more than two requests outstanding");

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_beat |-> pending_q != 2'd0)
		else $error("response beat with no request outstanding");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !req_ready)
		else $error("request taken while previous one still in work");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> value_out == '0)
		else $error("nonzero value on a rejected operation");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(value_out) && $stable(status))
		else $error("stalled response beat changed");

endmodule

bind grouped_team_queue_unit gtq_checker u_gtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.value_out (rsp.value_out),
	.status    (rsp.status)
);

/* bench/gtq_checker.sv */
module gtq_scoreboard #(
	parameter int POOL_SLOTS   = 1024,
	parameter int TEAM_COUNT   = 1024,
	parameter int ELEMENT_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	gtq_req_if   req,
	gtq_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	import gtq_pkg::*;

	localparam int ELEM_DEPTH = 1 << ELEMENT_BITS;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [STAT_W-1:0] status;
	} rsp_beat_t;

	rsp_beat_t due_q[$];
	rsp_beat_t want;
	int        err_count;

	// shadow of the queue: team table, slot pool, free list, team last-member pointers
	int team_of   [ELEM_DEPTH];
	int slot_elem [POOL_SLOTS];
	int slot_team [POOL_SLOTS];
	int slot_link [POOL_SLOTS];
	int team_tail [TEAM_COUNT];
	bit team_live [TEAM_COUNT];
	int head_idx;
	int tail_idx;
	int depth;
	int free_top;
	int fresh;

	task automatic flag_mismatch(input string msg);
		err_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic void wipe_queue();
		for (int i = 0; i < TEAM_COUNT; i++)
			team_live[i] = 1'b0;
		head_idx = 0;
		tail_idx = 0;
		depth    = 0;
		free_top = 0;
		fresh    = 0;
	endfunction

	function automatic rsp_beat_t queue_step(input logic [OP_W-1:0] op,
			input logic [ELEM_W-1:0] e_in, input logic [TEAM_W-1:0] t_in);
		rsp_beat_t r;
		int e;
		int t;
		int s;
		int f;
		int d;
		r = '0;
		e = int'(e_in) % ELEM_DEPTH;
		case (op)
			OP_MAP: begin
				if (int'(t_in) < TEAM_COUNT)
					team_of[e] = int'(t_in);
			end
			OP_ENQ: begin
				// free list first, then a never-used slot, else the pool is full
				if (depth < fresh) begin
					s = free_top % POOL_SLOTS;
					free_top = slot_link[s];
				end else if (fresh < POOL_SLOTS) begin
					s = fresh;
					fresh++;
				end else begin
					r.status = ST_FULL;
					return r;
				end
				t = team_of[e] % TEAM_COUNT;
				slot_elem[s] = e;
				slot_team[s] = t;
				if (team_live[t]) begin
					f = team_tail[t] % POOL_SLOTS;
					slot_link[s] = slot_link[f];
					slot_link[f] = s;
					if (tail_idx == f)
						tail_idx = s;
				end else begin
					if (depth == 0)
						head_idx = s;
					else
						slot_link[tail_idx % POOL_SLOTS] = s;
					tail_idx = s;
				end
				team_tail[t] = s;
				team_live[t] = 1'b1;
				depth++;
			end
			OP_DEQ: begin
				if (depth == 0) begin
					r.status = ST_EMPTY;
				end else begin
					d = head_idx % POOL_SLOTS;
					r.value = VAL_W'(slot_elem[d]);
					t = slot_team[d];
					if (team_live[t] && team_tail[t] == d)
						team_live[t] = 1'b0;
					head_idx = slot_link[d];
					depth--;
					slot_link[d] = free_top;
					free_top = d;
				end
			end
			default: wipe_queue();
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q.delete();
			wipe_queue();
			errors  <= 0;
			pending <= 0;
		end else begin
			// a response beat never belongs to a request taken at the same edge
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat value %0d status %0d",
						rsp.value_out, rsp.status));
				end else begin
					want = due_q.pop_front();
					if (rsp.value_out !== want.value)
						flag_mismatch($sformatf("value_out %0d, predicted %0d",
							rsp.value_out, want.value));
					if (rsp.status !== want.status)
						flag_mismatch($sformatf("status %0d, predicted %0d",
							rsp.status, want.status));
				end
			end
			if (req.valid && req.ready)
				due_q.push_back(queue_step(req.opcode, req.element, req.team_id));
			errors  <= err_count;
			pending <= due_q.size();
		end
	end

endmodule

/* bench/tb.sv */
module tb;
	import gtq_pkg::*;

	localparam int POOL_SLOTS   = 1024;
	localparam int TEAM_COUNT   = 1024;
	localparam int ELEMENT_BITS = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_OPS   = 900;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              req_valid = 1'b0;
	logic [OP_W-1:0]   req_op    = OP_MAP;
	logic [ELEM_W-1:0] req_elem  = '0;
	logic [TEAM_W-1:0] req_team  = '0;
	logic              rsp_take  = 1'b0;

	int errors;
	int pending;
	int cycles = 0;
	int depth  = 0;
	bit calm   = 1'b0;
	bit held   = 1'b0;
	bit mapped [1 << ELEMENT_BITS];
	int mapped_list[$];

	gtq_req_if req_ch();
	gtq_rsp_if rsp_ch();

	assign req_ch.valid   = req_valid;
	assign req_ch.opcode  = req_op;
	assign req_ch.element = req_elem;
	assign req_ch.team_id = req_team;
	assign rsp_ch.ready   = rsp_take;

	grouped_team_queue_unit #(
		.POOL_SLOTS(POOL_SLOTS),
		.TEAM_COUNT(TEAM_COUNT),
		.ELEMENT_BITS(ELEMENT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	gtq_scoreboard #(
		.POOL_SLOTS(POOL_SLOTS),
		.TEAM_COUNT(TEAM_COUNT),
		.ELEMENT_BITS(ELEMENT_BITS)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.errors(errors),
		.pending(pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk)
		rsp_take <= calm || ($urandom_range(99) >= 12);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("grouped_team_queue_unit regression: fail");
			$finish;
		end
	end

	// one request beat, then a random gap with valid low unless calm is set
	task automatic send_op(input logic [OP_W-1:0] op, input int e, input int t);
		req_valid <= 1'b1;
		req_op    <= op;
		req_elem  <= ELEM_W'(e);
		req_team  <= TEAM_W'(t);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		held = 1'b1;
		case (op)
			OP_MAP: begin
				if (t < TEAM_COUNT && !mapped[e]) begin
					mapped[e] = 1'b1;
					mapped_list.push_back(e);
				end
			end
			OP_ENQ: if (depth < POOL_SLOTS) depth++;
			OP_DEQ: if (depth > 0) depth--;
			default: depth = 0;
		endcase
		while (!calm && $urandom_range(99) < 12) begin
			req_valid <= 1'b0;
			held = 1'b0;
			@(posedge clk);
		end
	endtask

	// mostly a handful of teams so that groups form, sometimes any team
	function automatic int pick_team();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(7);
		if (r < 70)
			return TEAM_COUNT - 1 - $urandom_range(3);
		return $urandom_range(TEAM_COUNT - 1);
	endfunction

	task automatic map_rand();
		send_op(OP_MAP, $urandom_range(1023), pick_team());
	endtask

	// only elements that have been mapped are enqueued
	task automatic enq_rand();
		send_op(OP_ENQ, mapped_list[$urandom_range(mapped_list.size() - 1)],
			$urandom_range(1023));
	endtask

	task automatic deq_rand();
		send_op(OP_DEQ, $urandom_range(1023), $urandom_range(1023));
	endtask

	initial begin
		int r;
		int enq_cut;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty dequeue, field extremes, grouping, remap, clear
		deq_rand();
		send_op(OP_MAP, 0, 0);
		send_op(OP_MAP, 1023, 1023);
		send_op(OP_MAP, 'h155, 'h2aa);
		send_op(OP_MAP, 'h2aa, 'h155);
		send_op(OP_MAP, 5, 1023);
		send_op(OP_ENQ, 0, 0);
		send_op(OP_ENQ, 1023, 0);
		send_op(OP_ENQ, 'h155, 1023);
		send_op(OP_ENQ, 5, 'h3ff);
		send_op(OP_ENQ, 0, 0);
		// remap while queued, then insert behind the member at the tail
		send_op(OP_MAP, 0, 'h2aa);
		send_op(OP_ENQ, 0, 0);
		send_op(OP_ENQ, 'h2aa, 0);
		deq_rand();
		deq_rand();
		deq_rand();
		send_op(OP_CLR, 1023, 1023);
		deq_rand();
		send_op(OP_ENQ, 'h2aa, 0);
		send_op(OP_ENQ, 1023, 0);
		deq_rand();
		deq_rand();
		deq_rand();

		// fill the pool, hit full, reuse freed slots, then drain partly
		calm = 1'b1;
		while (depth < POOL_SLOTS) begin
			calm = (depth < 500);
			if ($urandom_range(9) == 0)
				map_rand();
			else
				enq_rand();
		end
		calm = 1'b0;
		repeat (3) enq_rand();
		deq_rand();
		enq_rand();
		enq_rand();
		repeat (400) begin
			if ($urandom_range(99) < 75)
				deq_rand();
			else if ($urandom_range(9) == 0)
				map_rand();
			else
				enq_rand();
		end
		send_op(OP_CLR, $urandom_range(1023), $urandom_range(1023));

		// enough clears to wrap the clear epoch
		for (int i = 0; i < 260; i++) begin
			send_op(OP_CLR, $urandom_range(1023), $urandom_range(1023));
			if (i % 16 == 0) begin
				enq_rand();
				enq_rand();
				deq_rand();
			end
		end

		for (int i = 0; i < RANDOM_OPS; i++) begin
			r = $urandom_range(99);
			enq_cut = (depth > 96) ? 45 : 62;
			if (r < 18)
				map_rand();
			else if (r < 20)
				send_op(OP_CLR, $urandom_range(1023), $urandom_range(1023));
			else if (r < enq_cut)
				enq_rand();
			else
				deq_rand();
		end

		if (held)
			req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("grouped_team_queue_unit regression: pass");
		else
			$display("grouped_team_queue_unit regression: fail");
		$finish;
	end

endmodule
